>>> rtl/core/ili_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed insert/remove list.
package ili_pkg;

    localparam int WORD_W   = 32;
    localparam int IDX_IN_W = 8;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_REMOVE = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     en;
        t_cell_op op;
    } t_cell_ctl;

endpackage

>>> rtl/core/indexed_insert_remove_list.sv
`timescale 1ns / 1ps
// Top level of the indexed insert/remove list: command decode, cell chain, result register.
//
//   channel   direction   handshake                  payload
//   command   in          i_in_valid / o_in_stall    i_command, i_index, i_value
//   result    out         o_out_valid / i_out_stall  o_read_value, o_status, o_count
//
// One command per cycle unless the result side stalls; its result appears in the output
// register on the next cycle. Every cell of the chain shifts or writes in the same cycle,
// so insert and remove are no slower than the other commands.
// Synchronous active-low reset clears the count and the output valid; words are not reset.
// A stalled result holds the output register and stalls the command side.
module indexed_insert_remove_list
    import ili_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [IDX_IN_W-1:0]      i_index,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [ST_W-1:0]          o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_rd   [DEPTH];
    logic [WORD_W-1:0] rd_or;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_rd;
    t_status           r_st;
    logic [CNT_W-1:0]  r_cnt_out;

    logic              accept;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [AW-1:0]     pos;
    logic              in_range;
    logic              full;
    logic              empty;
    t_cell_ctl         ctl;
    t_cell_op          cell_op;
    t_status           st;
    logic [WORD_W-1:0] rd;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign idx_ext  = CMP_W'(i_index);
    assign cnt_ext  = CMP_W'(r_count);
    assign in_range = (idx_ext < cnt_ext);
    assign full     = (r_count == CNT_MAX);
    assign empty    = (r_count == '0);

    always_comb begin
        cell_op = CELL_HOLD;
        st      = ST_OK;
        rd      = '0;
        pos_ext = idx_ext;
        n_count = r_count;
        unique case (t_cmd'(i_command))
            CMD_GET: begin
                if (in_range) rd = rd_or;
                else st = ST_RANGE;
            end
            CMD_SET: begin
                if (in_range) cell_op = CELL_WRITE;
                else st = ST_RANGE;
            end
            CMD_APPEND: begin
                pos_ext = cnt_ext;
                if (full) begin
                    st = ST_FULL;
                end else begin
                    cell_op = CELL_WRITE;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (empty) st = ST_EMPTY;
                else n_count = r_count - 1'b1;
            end
            CMD_INSERT: begin
                if (idx_ext > cnt_ext) pos_ext = cnt_ext;
                if (full) begin
                    st = ST_FULL;
                end else begin
                    cell_op = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!in_range) pos_ext = cnt_ext - 1'b1;
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    cell_op = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    assign pos    = pos_ext[AW-1:0];
    assign ctl.en = accept;
    assign ctl.op = cell_op;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] lo_word;
        logic [WORD_W-1:0] hi_word;
        if (k == 0) begin : g_first
            assign lo_word = '0;
        end else begin : g_lo
            assign lo_word = w_word[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign hi_word = '0;
        end else begin : g_hi
            assign hi_word = w_word[k+1];
        end
        ili_cell #(
            .AW  (AW),
            .POS (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_pos     (pos),
            .i_value   (i_value),
            .i_lo_word (lo_word),
            .i_hi_word (hi_word),
            .o_word    (w_word[k]),
            .o_rd      (w_rd[k])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | w_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd      <= rd;
            r_st      <= st;
            r_cnt_out <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_rd;
    assign o_status     = r_st;
    assign o_count      = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("count above depth");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat gave no result");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count == r_count))
        else $error("reported count differs from held count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == CNT_MAX))
        else $error("full status with list not full");

endmodule

>>> rtl/core/ili_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one word, shifts to/from its neighbors.
module ili_cell
    import ili_pkg::*;
#(
    parameter int AW  = 6,
    parameter int POS = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [AW-1:0]     i_pos,
    input  logic [WORD_W-1:0] i_value,
    input  logic [WORD_W-1:0] i_lo_word,
    input  logic [WORD_W-1:0] i_hi_word,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_rd
);

    localparam logic [AW-1:0] MY_POS = AW'(POS);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              hit;
    logic              above;

    assign hit   = (i_pos == MY_POS);
    assign above = (MY_POS > i_pos);

    always_comb begin
        n_word = r_word;
        if (i_ctl.en) begin
            case (i_ctl.op)
                CELL_WRITE: begin
                    if (hit) n_word = i_value;
                end
                CELL_INSERT: begin
                    if (hit) n_word = i_value;
                    else if (above) n_word = i_lo_word;
                end
                CELL_REMOVE: begin
                    if (hit || above) n_word = i_hi_word;
                end
                default: n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = hit ? r_word : '0;

endmodule

>>> tb/ili_list_checker.sv
`timescale 1ns / 1ps
// Checker for the indexed insert/remove list: mirrors the word list and compares every result beat.
module ili_list_checker
    import ili_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CNT_W = $clog2(DEPTH+1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [IDX_IN_W-1:0]      i_index,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [WORD_W-1:0] i_read_value,
    input  logic [ST_W-1:0]          i_status,
    input  logic [CNT_W-1:0]         i_count,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        logic signed [WORD_W-1:0] read_value;
        t_status                  status;
        logic [CNT_W-1:0]         count;
    } t_list_reply;

    logic signed [WORD_W-1:0] words [DEPTH];
    int                       held;
    t_list_reply              reply_q [$];

    function automatic t_list_reply list_reply_of(input logic [CMD_W-1:0] cmd,
                                                  input logic [IDX_IN_W-1:0] idx_in,
                                                  input logic signed [WORD_W-1:0] val);
        t_list_reply r;
        int          pos;
        int          n;
        r.read_value = '0;
        r.status     = ST_OK;
        n            = held;
        pos          = idx_in;
        case (cmd)
            CMD_GET: begin
                if (pos >= n) r.status = ST_RANGE;
                else r.read_value = words[pos];
            end
            CMD_SET: begin
                if (pos >= n) r.status = ST_RANGE;
                else words[pos] = val;
            end
            CMD_APPEND: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    words[n] = val;
                    n++;
                end
            end
            CMD_DELETE: begin
                if (n == 0) r.status = ST_EMPTY;
                else n--;
            end
            CMD_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (pos > n) pos = n;
                    for (int i = n; i > pos; i--) words[i] = words[i-1];
                    words[pos] = val;
                    n++;
                end
            end
            CMD_REMOVE: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (pos >= n) pos = n - 1;
                    for (int i = pos + 1; i < n; i++) words[i-1] = words[i];
                    n--;
                end
            end
            default: begin
            end
        endcase
        held    = n;
        r.count = CNT_W'(n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        if (!i_rst_n) begin
            held = 0;
            reply_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result beat (value %0d status %0d count %0d)",
                             $time, i_read_value, i_status, i_count);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reply_q.pop_front();
                    if (i_read_value !== want.read_value || i_status !== want.status ||
                        i_count !== want.count) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_read_value !== want.read_value)
                            $display("%0t: read_value expected %0d, got %0d",
                                     $time, want.read_value, i_read_value);
                        if (i_status !== want.status)
                            $display("%0t: status expected %0d, got %0d",
                                     $time, want.status, i_status);
                        if (i_count !== want.count)
                            $display("%0t: count expected %0d, got %0d",
                                     $time, want.count, i_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                reply_q.push_back(list_reply_of(i_command, i_index, i_value));
            o_pending <= reply_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the list testbench: clock, reset, command stimulus, result stalls and the verdict.
module testbench;
    import ili_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CNT_W     = $clog2(DEPTH+1);
    localparam int RAND_CMDS = 400;
    localparam int LIMIT     = 200000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command;
    logic [IDX_IN_W-1:0]      i_index;
    logic signed [WORD_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [WORD_W-1:0] o_read_value;
    logic [ST_W-1:0]          o_status;
    logic [CNT_W-1:0]         o_count;
    int                       fail_count;
    int                       pending;
    int                       cycles = 0;

    indexed_insert_remove_list #(.DEPTH(DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_value(o_read_value),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    ili_list_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_read_value(o_read_value),
        .i_status    (o_status),
        .i_count     (o_count),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // receiver stall pattern steps through four modes; also the run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        case ((cycles / 150) % 4)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 9) < 3);
            2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= ((cycles % 5) < 2);
        endcase
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_beat(input t_cmd cmd, input logic [IDX_IN_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_index    <= idx;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_all_replies;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int                       burst_left;
        int                       gap;
        int                       phase;
        int                       r;
        t_cmd                     cmd;
        logic [IDX_IN_W-1:0]      idx;
        logic signed [WORD_W-1:0] val;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = '0;
        i_index     = '0;
        i_value     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-list cases, extremes, insert/remove beyond the count
        send_beat(CMD_GET, 8'd0, 32'sd0);
        send_beat(CMD_SET, 8'd0, 32'sd5);
        send_beat(CMD_DELETE, 8'd0, 32'sd0);
        send_beat(CMD_REMOVE, 8'd5, 32'sd0);
        send_beat(CMD_APPEND, 8'd0, 32'h7FFF_FFFF);
        send_beat(CMD_APPEND, 8'd0, 32'h8000_0000);
        send_beat(CMD_INSERT, 8'd0, -32'sd1);
        send_beat(CMD_INSERT, 8'd255, 32'sd0);
        send_beat(CMD_INSERT, 8'd2, 32'h5555_5555);
        for (int i = 0; i < 5; i++) send_beat(CMD_GET, IDX_IN_W'(i), 32'sd0);
        send_beat(CMD_GET, 8'd5, 32'sd0);
        send_beat(CMD_GET, 8'd255, 32'sd0);
        send_beat(CMD_SET, 8'd1, 32'hAAAA_AAAA);
        send_beat(CMD_SET, 8'd200, 32'sd7);
        send_beat(CMD_GET, 8'd1, 32'sd0);
        send_beat(CMD_REMOVE, 8'd255, 32'sd0);
        send_beat(CMD_REMOVE, 8'd0, 32'sd0);
        send_beat(CMD_REMOVE, 8'd1, 32'sd0);
        send_beat(CMD_GET, 8'd0, 32'sd0);
        send_beat(CMD_DELETE, 8'd0, 32'sd0);
        send_beat(CMD_GET, 8'd0, 32'sd0);
        wait_all_replies();

        // phases: mixed, grow to full, churn at full, shrink to empty
        burst_left = 0;
        for (int k = 0; k < RAND_CMDS; k++) begin
            phase = k / (RAND_CMDS / 4);
            if (k == RAND_CMDS / 2) wait_all_replies();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;

            r = $urandom_range(0, 9);
            case (phase)
                0: cmd = t_cmd'($urandom_range(0, 5));
                1: cmd = (r < 5) ? CMD_APPEND : (r < 8) ? CMD_INSERT :
                         (r == 8) ? CMD_GET : CMD_SET;
                2: cmd = (r < 3) ? CMD_APPEND : (r < 5) ? CMD_INSERT :
                         (r == 6) ? CMD_SET : (r == 7) ? CMD_REMOVE :
                         (r == 8) ? CMD_DELETE : CMD_GET;
                default: cmd = (r < 4) ? CMD_DELETE : (r < 8) ? CMD_REMOVE :
                               (r == 8) ? CMD_GET : CMD_SET;
            endcase

            case ($urandom_range(0, 9))
                0, 1:    idx = IDX_IN_W'($urandom_range(0, 255));
                2, 3, 4: idx = IDX_IN_W'($urandom_range(0, 7));
                default: idx = IDX_IN_W'($urandom_range(0, DEPTH - 1));
            endcase

            case ($urandom_range(0, 5))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase

            send_beat(cmd, idx, val);
        end

        wait_all_replies();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
